// ===== hdl/aes128e_pkg.sv =====
// Shared constants and byte-level functions for the AES-128 encryption unit.
package aes128e_pkg;

  localparam int unsigned BlockW   = 128;
  localparam int unsigned HalfW    = 64;
  localparam int unsigned NumRound = 10;
  localparam int unsigned CfgIdxW  = 8;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegKeyLow  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegKeyHigh = CfgIdxW'(1);

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constants, indexed by the round whose key is being derived backwards.
  localparam logic [7:0] RCON [NumRound] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes and ShiftRows on a column-major state, byte i in bits 8i+7:8i.
  function automatic logic [BlockW-1:0] sub_shift(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [BlockW-1:0] mix_columns(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[32*c +: 8];
      a1  = s[32*c+8 +: 8];
      a2  = s[32*c+16 +: 8];
      a3  = s[32*c+24 +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[32*c +: 8]    = a0 ^ all ^ xtime(a0 ^ a1);
      t[32*c+8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
      t[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

endpackage

// ===== hdl/aes128e_key_sched.sv =====
// Round-10 key registers and the backward key schedule that fills the round keys.
module aes128e_key_sched import aes128e_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [HalfW-1:0]    cfg_data_i,
  output logic                busy_o,
  output logic [BlockW-1:0]   round_key_o [NumRound+1]
);

  logic [BlockW-1:0] key_q, key_d;
  logic [BlockW-1:0] work_q, work_d;
  logic [BlockW-1:0] rk_q [NumRound];
  logic [3:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              key_wr;
  logic [BlockW-1:0] prev_key;
  logic [31:0]       c3;

  // Decode the register write; unknown indexes leave the key alone.
  always_comb begin
    key_d  = key_q;
    key_wr = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegKeyLow: begin
          key_d[HalfW-1:0] = cfg_data_i;
          key_wr = 1'b1;
        end
        RegKeyHigh: begin
          key_d[BlockW-1:HalfW] = cfg_data_i;
          key_wr = 1'b1;
        end
        default: key_wr = 1'b0;
      endcase
    end
  end

  // One step of the inverse key schedule: round key cnt from round key cnt+1.
  always_comb begin
    c3 = work_q[127:96] ^ work_q[95:64];
    prev_key[127:96] = c3;
    prev_key[95:64]  = work_q[95:64] ^ work_q[63:32];
    prev_key[63:32]  = work_q[63:32] ^ work_q[31:0];
    prev_key[31:0]   = work_q[31:0] ^ {SBOX[c3[7:0]], SBOX[c3[31:24]], SBOX[c3[23:16]],
                                        SBOX[c3[15:8]] ^ RCON[cnt_q]};
  end

  // Sequencer control: a write restarts the walk from round nine down to zero.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    work_d = work_q;
    if (key_wr) begin
      busy_d = 1'b1;
      cnt_d  = 4'(NumRound - 1);
      work_d = key_d;
    end else if (busy_q) begin
      work_d = prev_key;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      work_q <= '0;
      busy_q <= 1'b1;
      cnt_q  <= 4'(NumRound - 1);
    end else begin
      key_q  <= key_d;
      work_q <= work_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Round key store, written one entry per step of the walk.
  always_ff @(posedge clk_i) begin
    if (busy_q && !key_wr) begin
      rk_q[cnt_q] <= prev_key;
    end
  end

  always_comb begin
    for (int r = 0; r < NumRound; r++) begin
      round_key_o[r] = rk_q[r];
    end
    round_key_o[NumRound] = key_q;
  end

  assign busy_o = busy_q;

endmodule

// ===== hdl/aes128e_round.sv =====
// One registered AES round stage of the encryption pipeline.
module aes128e_round import aes128e_pkg::*; #(
  parameter bit IsFinal = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [BlockW-1:0] state_i,
  input  logic [BlockW-1:0] key_i,
  output logic              valid_o,
  output logic [BlockW-1:0] state_o
);

  logic [BlockW-1:0] ss, state_d, state_q;
  logic              valid_q;

  // SubBytes, ShiftRows, MixColumns except in the last round, then the key.
  always_comb begin
    ss = sub_shift(state_i);
    if (IsFinal) begin
      state_d = ss ^ key_i;
    end else begin
      state_d = mix_columns(ss) ^ key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

// ===== hdl/aes128_encrypt_from_last_round_key_unit.sv =====
// Top level: AES-128 encryption pipeline keyed by the round-10 key.
// Pipeline: 11 register stages (one key-add stage, ten rounds); a block taken in is held in
// the key-add register, then passes through the ten round registers to out_valid_o.
// Throughput: one block per cycle; the whole pipeline holds while the result is not taken.
// After reset and after each key write the backward key schedule runs, and while it runs
// no input request is accepted. Reset loads an all-zero round-10 key.
module aes128_encrypt_from_last_round_key_unit import aes128e_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [HalfW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [HalfW-1:0]   plain_low_i,
  input  logic [HalfW-1:0]   plain_high_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [HalfW-1:0]   cipher_low_o,
  output logic [HalfW-1:0]   cipher_high_o
);

  logic              busy;
  logic [BlockW-1:0] round_key [NumRound+1];
  logic              en;
  logic              valid [NumRound+1];
  logic [BlockW-1:0] state [NumRound+1];
  logic              v0_q;
  logic [BlockW-1:0] s0_q;

  aes128e_key_sched u_key_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .round_key_o (round_key)
  );

  // The pipeline moves whenever the output stage is empty or being taken.
  assign en          = !valid[NumRound] || out_ready_i;
  assign in_ready_o  = en && !busy;
  assign cfg_ready_o = 1'b1;

  // Initial key addition stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= {plain_high_i, plain_low_i} ^ round_key[0];
    end
  end

  assign valid[0] = v0_q;
  assign state[0] = s0_q;

  // Ten round stages, the last one without MixColumns.
  for (genvar r = 1; r <= NumRound; r++) begin : g_round
    aes128e_round #(
      .IsFinal (r == NumRound)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid[r-1]),
      .state_i (state[r-1]),
      .key_i   (round_key[r]),
      .valid_o (valid[r]),
      .state_o (state[r])
    );
  end

  assign out_valid_o   = valid[NumRound];
  assign cipher_low_o  = state[NumRound][HalfW-1:0];
  assign cipher_high_o = state[NumRound][BlockW-1:HalfW];

endmodule
